// ===== rtl/pst_pkg.sv =====
// Package: payload types and constants for the pose servo twist law block.
package pst_pkg;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic signed [15:0] tx;
    logic signed [15:0] ty;
    logic signed [15:0] tz;
  } pose_t;

  typedef struct packed {
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
    logic signed [23:0] wx;
    logic signed [23:0] wy;
    logic signed [23:0] wz;
  } twist_t;

  typedef enum logic [2:0] {
    REG_GAIN     = 3'd0,
    REG_HALT     = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_OFFSET_Y = 3'd3,
    REG_OFFSET_Z = 3'd4
  } reg_idx_t;

  localparam logic [15:0]        GAIN_RST = 16'd6144;
  localparam logic signed [15:0] OFFY_RST = 16'sd225;
  localparam int                 NSTG     = 8;

  // round half up then arithmetic shift
  function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int s);
    logic signed [63:0] y;
    y = x + (64'sd1 <<< (s - 1));
    return y >>> s;
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [63:0] x);
    if (x > 64'sd8388607) return 24'sh7FFFFF;
    else if (x < -64'sd8388608) return 24'sh800000;
    else return x[23:0];
  endfunction

endpackage

// ===== rtl/pose_servo_twist_law.sv =====
// Top level: pipelined position-based visual servo twist law.
// An accepted pose word passes stages 1 to 7 and then the output register on its way to the output.
// Throughput: one word per cycle; the stage chain advances when the output is free.
// Multiplier stages (errors, rotation products, cross products, gain) set the depth.
// Reset (rst_n low, synchronous): pipeline empty, reference cleared, registers
// back to gain 1.5, halt 0, offset (0, 225, 0).
module pose_servo_twist_law (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pst_pkg::pose_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pst_pkg::twist_t   out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  logic [15:0]        gain_r;
  logic               halt_r;
  logic signed [15:0] ox_r, oy_r, oz_r;
  logic signed [15:0] rr_r [9];
  logic signed [15:0] rt_r [3];
  logic               have_r;

  logic [pst_pkg::NSTG-1:0] v_r;
  logic adv;
  logic in_acc;

  assign cfg_ready = 1'b1;
  assign adv       = !v_r[pst_pkg::NSTG-1] || out_ready;
  assign in_ready  = adv;
  assign in_acc    = in_valid && in_ready;
  assign out_valid = v_r[pst_pkg::NSTG-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= pst_pkg::GAIN_RST;
      halt_r <= 1'b0;
      ox_r   <= '0;
      oy_r   <= pst_pkg::OFFY_RST;
      oz_r   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        pst_pkg::REG_GAIN:     gain_r <= cfg_data;
        pst_pkg::REG_HALT:     halt_r <= cfg_data[0];
        pst_pkg::REG_OFFSET_X: ox_r   <= cfg_data;
        pst_pkg::REG_OFFSET_Y: oy_r   <= cfg_data;
        pst_pkg::REG_OFFSET_Z: oz_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // incoming pose as arrays
  logic signed [15:0] rin [9];
  logic signed [15:0] tin [3];
  assign rin[0] = in_data.r00; assign rin[1] = in_data.r01; assign rin[2] = in_data.r02;
  assign rin[3] = in_data.r10; assign rin[4] = in_data.r11; assign rin[5] = in_data.r12;
  assign rin[6] = in_data.r20; assign rin[7] = in_data.r21; assign rin[8] = in_data.r22;
  assign tin[0] = in_data.tx;  assign tin[1] = in_data.ty;  assign tin[2] = in_data.tz;

  // reference used by this word: the word itself when no reference is held yet
  logic signed [15:0] rref [9];
  logic signed [15:0] tref [3];
  always_comb begin
    for (int i = 0; i < 9; i++) rref[i] = have_r ? rr_r[i] : rin[i];
    for (int i = 0; i < 3; i++) tref[i] = have_r ? rt_r[i] : tin[i];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      for (int i = 0; i < 9; i++) rr_r[i] <= '0;
      for (int i = 0; i < 3; i++) rt_r[i] <= '0;
    end else if (in_acc && !have_r) begin
      have_r <= 1'b1;
      for (int i = 0; i < 9; i++) rr_r[i] <= rin[i];
      for (int i = 0; i < 3; i++) rt_r[i] <= tin[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (adv) v_r <= {v_r[pst_pkg::NSTG-2:0], in_acc};
  end

  // stage 1: register pose, d, skew products of R^T Rd
  logic signed [15:0] s1_r [9];
  logic signed [15:0] s1t_r [3];
  logic signed [16:0] s1d_r [3];
  logic signed [33:0] s1m_r [6]; // m01 m10 m02 m20 m12 m21
  // stage 2: e_t, e_w
  logic signed [15:0] s2_r [9];
  logic signed [15:0] s2t_r [3];
  logic signed [23:0] s2et_r [3];
  logic signed [21:0] s2ew_r [3];
  // stage 3: p, q
  logic signed [15:0] s3t_r [3];
  logic signed [23:0] s3p_r [3];
  logic signed [41:0] s3q_r [3];
  // stage 4: a, cross t x p, q
  logic signed [23:0] s4a_r [3];
  logic signed [41:0] s4c_r [3];
  logic signed [41:0] s4q_r [3];
  // stage 5: ul, o x a products
  logic signed [23:0] s5a_r [3];
  logic signed [29:0] s5ul_r [3];
  logic signed [40:0] s5oc_r [3];
  // stage 6: l
  logic signed [23:0] s6a_r [3];
  logic signed [31:0] s6l_r [3];
  // stage 7: gain products
  logic signed [48:0] s7l_r [3];
  logic signed [40:0] s7a_r [3];
  logic               s7h_r;

  function automatic logic signed [33:0] mt(input logic signed [15:0] r [9],
      input logic signed [15:0] q [9], input int a, input int k);
    return 34'(r[a] * q[k]) + 34'(r[3 + a] * q[3 + k]) + 34'(r[6 + a] * q[6 + k]);
  endfunction

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 9; i++) s1_r[i] <= rin[i];
      for (int i = 0; i < 3; i++) begin
        s1t_r[i] <= tin[i];
        s1d_r[i] <= 17'(tref[i]) - 17'(tin[i]);
      end
      s1m_r[0] <= mt(rin, rref, 0, 1);
      s1m_r[1] <= mt(rin, rref, 1, 0);
      s1m_r[2] <= mt(rin, rref, 0, 2);
      s1m_r[3] <= mt(rin, rref, 2, 0);
      s1m_r[4] <= mt(rin, rref, 1, 2);
      s1m_r[5] <= mt(rin, rref, 2, 1);

      for (int i = 0; i < 9; i++) s2_r[i] <= s1_r[i];
      for (int i = 0; i < 3; i++) begin
        s2t_r[i] <= s1t_r[i];
        s2et_r[i] <= 24'(pst_pkg::rnd(64'(s1_r[i] * s1d_r[0]) + 64'(s1_r[3 + i] * s1d_r[1])
                        + 64'(s1_r[6 + i] * s1d_r[2]), 10));
      end
      s2ew_r[0] <= 22'(pst_pkg::rnd(64'(s1m_r[5]) - 64'(s1m_r[4]), 13));
      s2ew_r[1] <= 22'(pst_pkg::rnd(64'(s1m_r[2]) - 64'(s1m_r[3]), 13));
      s2ew_r[2] <= 22'(pst_pkg::rnd(64'(s1m_r[1]) - 64'(s1m_r[0]), 13));

      for (int i = 0; i < 3; i++) begin
        s3t_r[i] <= s2t_r[i];
        s3p_r[i] <= 24'(pst_pkg::rnd(64'(s2_r[3*i] * s2ew_r[0]) + 64'(s2_r[3*i+1] * s2ew_r[1])
                        + 64'(s2_r[3*i+2] * s2ew_r[2]), 14));
        s3q_r[i] <= 42'(s2_r[3*i] * s2et_r[0]) + 42'(s2_r[3*i+1] * s2et_r[1])
                    + 42'(s2_r[3*i+2] * s2et_r[2]);
      end

      s4a_r[0] <= s3p_r[0];
      s4a_r[1] <= s3p_r[1];
      s4a_r[2] <= -s3p_r[2];
      s4c_r[0] <= 42'(s3t_r[1] * s3p_r[2]) - 42'(s3t_r[2] * s3p_r[1]);
      s4c_r[1] <= 42'(s3t_r[2] * s3p_r[0]) - 42'(s3t_r[0] * s3p_r[2]);
      s4c_r[2] <= 42'(s3t_r[0] * s3p_r[1]) - 42'(s3t_r[1] * s3p_r[0]);
      for (int i = 0; i < 3; i++) s4q_r[i] <= s3q_r[i];

      for (int i = 0; i < 3; i++) begin
        s5a_r[i]  <= s4a_r[i];
        s5ul_r[i] <= 30'(pst_pkg::rnd(-64'(s4q_r[i]) - (64'(s4c_r[i]) <<< 2), 14));
      end
      s5oc_r[0] <= 41'(oy_r * s4a_r[2]) - 41'(oz_r * s4a_r[1]);
      s5oc_r[1] <= 41'(oz_r * s4a_r[0]) - 41'(ox_r * s4a_r[2]);
      s5oc_r[2] <= 41'(ox_r * s4a_r[1]) - 41'(oy_r * s4a_r[0]);

      for (int i = 0; i < 3; i++) begin
        s6a_r[i] <= s5a_r[i];
        s6l_r[i] <= 32'((i == 2 ? 64'(s5ul_r[i]) : -64'(s5ul_r[i]))
                        + pst_pkg::rnd(64'(s5oc_r[i]), 12));
      end

      for (int i = 0; i < 3; i++) begin
        s7l_r[i] <= 49'(s6l_r[i] * $signed({1'b0, gain_r}));
        s7a_r[i] <= 41'(s6a_r[i] * $signed({1'b0, gain_r}));
      end
      s7h_r <= halt_r;

      out_data.vx <= s7h_r ? '0 : pst_pkg::sat24(pst_pkg::rnd(64'(s7l_r[0]), 16));
      out_data.vy <= s7h_r ? '0 : pst_pkg::sat24(pst_pkg::rnd(64'(s7l_r[1]), 16));
      out_data.vz <= s7h_r ? '0 : pst_pkg::sat24(pst_pkg::rnd(64'(s7l_r[2]), 16));
      out_data.wx <= s7h_r ? '0 : pst_pkg::sat24(pst_pkg::rnd(64'(s7a_r[0]) * 64'sd100, 16));
      out_data.wy <= s7h_r ? '0 : pst_pkg::sat24(pst_pkg::rnd(64'(s7a_r[1]) * 64'sd100, 16));
      out_data.wz <= s7h_r ? '0 : pst_pkg::sat24(pst_pkg::rnd(64'(s7a_r[2]) * 64'sd100, 16));
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word changed under stall");
  a_ref_once: assert property (@(posedge clk) disable iff (!rst_n)
    have_r |=> have_r && $stable(rt_r[0]))
    else $error("reference changed after latch");
  a_first_latch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !have_r |=> have_r)
    else $error("first word not latched");

endmodule

// ===== tb/sv/pose_servo_twist_law_tb.sv =====
// Testbench for pose_servo_twist_law: directed and randomized poses and settings against a twist predictor.
`timescale 1ns / 100ps

module pose_servo_twist_law_tb;

  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pst_pkg::pose_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pst_pkg::twist_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  pose_servo_twist_law DUT (.*);

  always #10 clk = ~clk;

  pst_pkg::pose_t pose_q[$];
  pst_pkg::twist_t twist_q[$];
  int errors = 0;
  int cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;
  int hold_cycles = 0;
  logic in_taken = 1'b0;
  logic [15:0] gains[4] = '{16'd0, 16'hFFFF, 16'd4096, 16'd6144};

  // predictor state
  longint p_gain = 6144, p_halt = 0, p_off[3] = '{0, 225, 0};
  longint ref_t[3], ref_r[9];
  bit have_ref = 0;

  function automatic longint rshift(longint x, int s);
    return (x + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [23:0] clamp24(longint x);
    if (x > 8388607) return 24'sh7FFFFF;
    if (x < -8388608) return 24'sh800000;
    return x[23:0];
  endfunction

  function automatic pst_pkg::twist_t twist_of(pst_pkg::pose_t ps);
    longint r[9], t[3], d[3], et[3], ew[3], p[3], q[3], c[3], ul[3], a[3], oc[3], l[3];
    longint s, u, m[3][3];
    pst_pkg::twist_t tw;
    r = '{ps.r00, ps.r01, ps.r02, ps.r10, ps.r11, ps.r12, ps.r20, ps.r21, ps.r22};
    t = '{ps.tx, ps.ty, ps.tz};
    if (!have_ref) begin
      ref_r = r;
      ref_t = t;
      have_ref = 1;
    end
    if (p_halt != 0) return '0;
    for (int i = 0; i < 3; i++) d[i] = ref_t[i] - t[i];
    for (int i = 0; i < 3; i++) begin
      s = 0;
      for (int j = 0; j < 3; j++) s += r[j*3+i] * d[j];
      et[i] = rshift(s, 10);
    end
    for (int i = 0; i < 3; i++)
      for (int k = 0; k < 3; k++)
        m[i][k] = r[i] * ref_r[k] + r[3+i] * ref_r[3+k] + r[6+i] * ref_r[6+k];
    ew[0] = rshift(m[2][1] - m[1][2], 13);
    ew[1] = rshift(m[0][2] - m[2][0], 13);
    ew[2] = rshift(m[1][0] - m[0][1], 13);
    for (int i = 0; i < 3; i++) begin
      s = 0;
      u = 0;
      for (int j = 0; j < 3; j++) begin
        s += r[i*3+j] * ew[j];
        u += r[i*3+j] * et[j];
      end
      p[i] = rshift(s, 14);
      q[i] = u;
    end
    c[0] = t[1] * p[2] - t[2] * p[1];
    c[1] = t[2] * p[0] - t[0] * p[2];
    c[2] = t[0] * p[1] - t[1] * p[0];
    for (int i = 0; i < 3; i++) ul[i] = rshift(-q[i] - 4 * c[i], 14);
    a = '{p[0], p[1], -p[2]};
    oc[0] = rshift(p_off[1] * a[2] - p_off[2] * a[1], 12);
    oc[1] = rshift(p_off[2] * a[0] - p_off[0] * a[2], 12);
    oc[2] = rshift(p_off[0] * a[1] - p_off[1] * a[0], 12);
    l = '{-ul[0] + oc[0], -ul[1] + oc[1], ul[2] + oc[2]};
    tw.vx = clamp24(rshift(l[0] * p_gain, 16));
    tw.vy = clamp24(rshift(l[1] * p_gain, 16));
    tw.vz = clamp24(rshift(l[2] * p_gain, 16));
    tw.wx = clamp24(rshift(a[0] * p_gain * 100, 16));
    tw.wy = clamp24(rshift(a[1] * p_gain * 100, 16));
    tw.wz = clamp24(rshift(a[2] * p_gain * 100, 16));
    return tw;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst_n && (!in_valid || in_taken)) begin
      if (pose_q.size() > 0 && $urandom_range(99) >= send_idle) begin
        in_data <= pose_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_idle);
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_taken <= in_valid && in_ready;
    if (in_valid && in_ready) twist_q.push_back(twist_of(in_data));
    if (out_valid && out_ready) begin
      if (twist_q.size() == 0) begin
        $error("twist word with no expectation");
        errors++;
      end else begin
        pst_pkg::twist_t e;
        e = twist_q.pop_front();
        if (e.vx !== out_data.vx) begin $error("vx exp %0d got %0d", e.vx, out_data.vx); errors++; end
        if (e.vy !== out_data.vy) begin $error("vy exp %0d got %0d", e.vy, out_data.vy); errors++; end
        if (e.vz !== out_data.vz) begin $error("vz exp %0d got %0d", e.vz, out_data.vz); errors++; end
        if (e.wx !== out_data.wx) begin $error("wx exp %0d got %0d", e.wx, out_data.wx); errors++; end
        if (e.wy !== out_data.wy) begin $error("wy exp %0d got %0d", e.wy, out_data.wy); errors++; end
        if (e.wz !== out_data.wz) begin $error("wz exp %0d got %0d", e.wz, out_data.wz); errors++; end
      end
    end
    if (cycles >= LIMIT) begin
      $display("pose_servo_twist_law test failed");
      $finish;
    end
  end

  task automatic write_reg(pst_pkg::reg_idx_t idx, logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      pst_pkg::REG_GAIN: p_gain = val;
      pst_pkg::REG_HALT: p_halt = val[0];
      pst_pkg::REG_OFFSET_X: p_off[0] = $signed(val);
      pst_pkg::REG_OFFSET_Y: p_off[1] = $signed(val);
      pst_pkg::REG_OFFSET_Z: p_off[2] = $signed(val);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pose_q.size() > 0 || in_valid || twist_q.size() > 0) @(posedge clk);
    repeat (pst_pkg::NSTG + 4) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rot_entry();
    case ($urandom_range(5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sd0;
      3: return 16'($urandom());
      default: return $signed(16'($urandom_range(32768))) - 16'sd16384;
    endcase
  endfunction

  function automatic pst_pkg::pose_t rand_pose();
    pst_pkg::pose_t ps;
    ps.r00 = rot_entry(); ps.r01 = rot_entry(); ps.r02 = rot_entry();
    ps.r10 = rot_entry(); ps.r11 = rot_entry(); ps.r12 = rot_entry();
    ps.r20 = rot_entry(); ps.r21 = rot_entry(); ps.r22 = rot_entry();
    ps.tx = 16'($urandom()); ps.ty = 16'($urandom()); ps.tz = 16'($urandom());
    if ($urandom_range(3) == 0) begin
      ps.tx = $signed(16'($urandom_range(8191))) - 16'sd4096;
      ps.ty = $signed(16'($urandom_range(8191))) - 16'sd4096;
    end
    return ps;
  endfunction

  function automatic pst_pkg::pose_t flat_pose(logic signed [15:0] rv, logic signed [15:0] tv);
    pst_pkg::pose_t ps;
    ps = '{default: rv};
    ps.tx = tv; ps.ty = tv; ps.tz = tv;
    return ps;
  endfunction

  initial begin
    pst_pkg::pose_t ps;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // reference is identity at origin, halt on the first word
    write_reg(pst_pkg::REG_HALT, 16'd1);
    ps = '0;
    ps.r00 = 16'sd16384; ps.r11 = 16'sd16384; ps.r22 = 16'sd16384;
    pose_q.push_back(ps);
    drain();
    write_reg(pst_pkg::REG_HALT, 16'd0);
    pose_q.push_back(ps);
    pose_q.push_back(flat_pose(16'sd16384, 16'sh7FFF));
    pose_q.push_back(flat_pose(-16'sd16384, -16'sh8000));
    pose_q.push_back(flat_pose(16'sh7FFF, 16'sh7FFF));
    pose_q.push_back(flat_pose(-16'sh8000, -16'sh8000));
    pose_q.push_back(flat_pose(16'sh5555, 16'shAAAA));
    pose_q.push_back(flat_pose(16'shAAAA, 16'sh5555));
    ps = '0;
    ps.r01 = -16'sd16384; ps.r10 = 16'sd16384; ps.r22 = 16'sd16384; ps.tx = 16'sd4096;
    pose_q.push_back(ps);
    ps = '0;
    ps.r02 = 16'sd16384; ps.r11 = 16'sd16384; ps.r20 = -16'sd16384; ps.tz = -16'sd8192;
    pose_q.push_back(ps);
    for (int k = 0; k < 8; k++) pose_q.push_back(rand_pose());
    drain();
    write_reg(pst_pkg::REG_OFFSET_X, 16'h7FFF);
    write_reg(pst_pkg::REG_OFFSET_Y, 16'h8000);
    write_reg(pst_pkg::REG_OFFSET_Z, 16'h8000);
    write_reg(pst_pkg::REG_GAIN, 16'hFFFF);
    for (int k = 0; k < 6; k++) pose_q.push_back(rand_pose());
    drain();
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 3)
        0: begin send_idle = 29; recv_idle = 88; end
        1: begin send_idle = 88; recv_idle = 29; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      write_reg(pst_pkg::REG_GAIN, ph < 4 ? gains[ph] : 16'($urandom()));
      write_reg(pst_pkg::REG_HALT, 16'(ph == 7));
      write_reg(pst_pkg::REG_OFFSET_X, 16'($urandom()));
      write_reg(pst_pkg::REG_OFFSET_Y, 16'($urandom()));
      write_reg(pst_pkg::REG_OFFSET_Z, 16'($urandom()));
      if (ph == 2) hold_cycles = 200;
      for (int k = 0; k < 100; k++) pose_q.push_back(rand_pose());
      drain();
    end
    if (errors == 0) $display("pose_servo_twist_law test passed");
    else $display("pose_servo_twist_law test failed");
    $finish;
  end

endmodule
